/* rtl/mqrb_pkg.sv */
// Shared constants for the byte ring queue pool: field widths, operation and status codes.
`default_nettype none

package mqrb_pkg;

  // Default pool geometry
  localparam int QUEUE_COUNT_DEF    = 4;
  localparam int QUEUE_CAPACITY_DEF = 256;

  // Port field widths
  localparam int KIND_W   = 3;
  localparam int QSEL_W   = 2;
  localparam int LEN_W    = 9;
  localparam int BYTE_W   = 8;
  localparam int STAT_W   = 2;
  localparam int HANDLE_W = 2;
  localparam int FILLO_W  = 9;

  // Operation codes
  localparam logic [KIND_W-1:0] KIND_ALLOC = 3'd0;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 3'd1;
  localparam logic [KIND_W-1:0] KIND_PUT   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_GET   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_COUNT = 3'd4;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOFREE = 2'd1;
  localparam logic [STAT_W-1:0] ST_BUSY   = 2'd2;
  localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd3;

endpackage

`default_nettype wire

/* rtl/mqrb_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module mqrb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* rtl/multi_queue_byte_ring_buffer.sv */
// Pool of byte ring queues sharing one byte store, with per-queue pointer and fill memory.
//
// Usage:
//   Command channel: present in_kind, in_queue, in_block_len, in_first and
//   in_data_in with start high; the word is taken at a rising edge where
//   busy is low. busy is high in the execute phase after each accepted word.
//   Result channel: out_valid is high for exactly one cycle with out_status,
//   out_data_out, out_handle and out_fill_count; the receiver cannot stall
//   and must take the word in that cycle.
//   The result is registered: the accept edge enters the execute phase, and
//   the result loads as that phase ends. busy holds off a new word until the
//   read-modify-write of the queue pointer memory is done (read issued at
//   accept, written back as execute ends); the next accept sees the update.
//   A get reads its byte from the byte store in the same cycle as the
//   pointer write-back, so both kinds share the same latency.
//   Reset: synchronous, active low. Head, tail and fill of every queue read
//   as zero through per-entry valid bits; the allocate count and the block
//   decision clear. The byte store is not cleared and needs no clearing
//   pass: a get only returns bytes that a put wrote.
`default_nettype none

module multi_queue_byte_ring_buffer import mqrb_pkg::*; #(
  parameter int QUEUE_COUNT    = QUEUE_COUNT_DEF,
  parameter int QUEUE_CAPACITY = QUEUE_CAPACITY_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [KIND_W-1:0]   in_kind,
  input  wire logic [QSEL_W-1:0]   in_queue,
  input  wire logic [LEN_W-1:0]    in_block_len,
  input  wire logic                in_first,
  input  wire logic [BYTE_W-1:0]   in_data_in,
  output logic                     out_valid,
  output logic [STAT_W-1:0]        out_status,
  output logic [BYTE_W-1:0]        out_data_out,
  output logic [HANDLE_W-1:0]      out_handle,
  output logic [FILLO_W-1:0]       out_fill_count
);

  localparam int QW  = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;
  localparam int PW  = $clog2(QUEUE_CAPACITY);
  localparam int FW  = $clog2(QUEUE_CAPACITY + 1);
  localparam int AW  = $clog2(QUEUE_COUNT + 1);
  localparam int SW  = ((FW > LEN_W) ? FW : LEN_W) + 1;
  localparam int BD  = QUEUE_COUNT * QUEUE_CAPACITY;
  localparam int BW  = (BD > 1) ? $clog2(BD) : 1;
  localparam int MW  = 2 * PW + FW;

  localparam logic PH_IDLE = 1'b0;
  localparam logic PH_EXEC = 1'b1;

  // Control state
  logic            phase_r, phase_nxt;
  logic            out_valid_r;
  logic            blk_acc_r, blk_acc_nxt;
  logic [AW-1:0]   alloc_cnt_r, alloc_cnt_nxt;
  logic [QUEUE_COUNT-1:0] meta_vld_r;

  // Captured command word
  logic [KIND_W-1:0] kind_r;
  logic [QW-1:0]     q_r;
  logic              oob_r;
  logic              vld_sel_r;
  logic [LEN_W-1:0]  len_r;
  logic              first_r;
  logic [BYTE_W-1:0] din_r;

  // Result registers
  logic [STAT_W-1:0]   out_status_r, status_nxt;
  logic [HANDLE_W-1:0] out_handle_r, handle_nxt;
  logic [FW-1:0]       out_fill_r, fill_out_nxt;
  logic                out_get_r, get_hit;

  logic          accept;
  logic [QW-1:0] in_idx;
  logic          in_oob;

  // Pointer memory ports
  logic          meta_we;
  logic [QW-1:0] meta_waddr;
  logic [MW-1:0] meta_wdata, meta_rdata;

  // Byte store ports
  logic              byte_we;
  logic [BW-1:0]     byte_waddr, byte_raddr, q_base;
  logic [BYTE_W-1:0] byte_rdata;

  logic [PW-1:0] head, tail, head_inc, tail_inc;
  logic [FW-1:0] fill;
  logic          blk_ok;
  logic          move;
  logic [STAT_W-1:0] refuse;

  assign accept = start && !busy;
  assign busy   = (phase_r == PH_EXEC);
  assign in_idx = QW'(in_queue);
  assign in_oob = (32'(in_queue) >= 32'(QUEUE_COUNT));

  mqrb_ram #(.WIDTH(MW), .DEPTH(QUEUE_COUNT)) u_meta_ram (
    .clk   (clk),
    .we    (meta_we),
    .waddr (meta_waddr),
    .wdata (meta_wdata),
    .raddr (in_idx),
    .rdata (meta_rdata)
  );

  mqrb_ram #(.WIDTH(BYTE_W), .DEPTH(BD)) u_byte_ram (
    .clk   (clk),
    .we    (byte_we),
    .waddr (byte_waddr),
    .wdata (din_r),
    .raddr (byte_raddr),
    .rdata (byte_rdata)
  );

  // Entries never written read as an empty queue
  always_comb begin
    if (vld_sel_r) begin
      {head, tail, fill} = meta_rdata;
    end else begin
      head = '0;
      tail = '0;
      fill = '0;
    end
  end

  assign head_inc   = (head == PW'(QUEUE_CAPACITY - 1)) ? '0 : head + PW'(1);
  assign tail_inc   = (tail == PW'(QUEUE_CAPACITY - 1)) ? '0 : tail + PW'(1);
  assign q_base     = BW'(q_r) * BW'(QUEUE_CAPACITY);
  assign byte_waddr = q_base + BW'(tail);
  assign byte_raddr = q_base + BW'(head);
  assign refuse     = (kind_r == KIND_PUT) ? ST_BUSY : ST_EMPTY;

  always_comb begin
    if (kind_r == KIND_PUT) begin
      blk_ok = (SW'(fill) + SW'(len_r)) <= SW'(QUEUE_CAPACITY);
    end else begin
      blk_ok = SW'(fill) >= SW'(len_r);
    end
  end

  // Execute one command word against the pointer entry read at accept
  always_comb begin
    status_nxt    = ST_OK;
    handle_nxt    = '0;
    fill_out_nxt  = '0;
    meta_we       = 1'b0;
    meta_waddr    = q_r;
    meta_wdata    = {head, tail, fill};
    byte_we       = 1'b0;
    get_hit       = 1'b0;
    blk_acc_nxt   = blk_acc_r;
    alloc_cnt_nxt = alloc_cnt_r;
    move          = 1'b0;
    phase_nxt     = accept ? PH_EXEC : PH_IDLE;

    if (phase_r == PH_EXEC) begin
      unique case (kind_r)
        KIND_ALLOC: begin
          if (alloc_cnt_r == AW'(QUEUE_COUNT)) begin
            status_nxt = ST_NOFREE;
          end else begin
            handle_nxt    = HANDLE_W'(alloc_cnt_r);
            meta_we       = 1'b1;
            meta_waddr    = QW'(alloc_cnt_r);
            meta_wdata    = '0;
            alloc_cnt_nxt = alloc_cnt_r + AW'(1);
          end
        end
        KIND_CLEAR: begin
          if (oob_r) begin
            status_nxt = ST_NOFREE;
          end else begin
            meta_we    = 1'b1;
            meta_wdata = '0;
          end
        end
        KIND_PUT, KIND_GET: begin
          if (oob_r) begin
            status_nxt = ST_NOFREE;
          end else begin
            priority if (first_r) begin
              if (len_r == '0) begin
                blk_acc_nxt = 1'b0;
              end else begin
                blk_acc_nxt = blk_ok;
                if (blk_ok) begin
                  move = 1'b1;
                end else begin
                  status_nxt = refuse;
                end
              end
            end else if (blk_acc_r) begin
              move = 1'b1;
            end else begin
              status_nxt = refuse;
            end
            fill_out_nxt = fill;
            if (move) begin
              if (kind_r == KIND_PUT) begin
                if (fill == FW'(QUEUE_CAPACITY)) begin
                  status_nxt = ST_BUSY;
                end else begin
                  byte_we      = 1'b1;
                  meta_we      = 1'b1;
                  meta_wdata   = {head, tail_inc, fill + FW'(1)};
                  fill_out_nxt = fill + FW'(1);
                end
              end else begin
                if (fill == '0) begin
                  status_nxt = ST_EMPTY;
                end else begin
                  get_hit      = 1'b1;
                  meta_we      = 1'b1;
                  meta_wdata   = {head_inc, tail, fill - FW'(1)};
                  fill_out_nxt = fill - FW'(1);
                end
              end
            end
          end
        end
        KIND_COUNT: begin
          if (oob_r) begin
            status_nxt = ST_NOFREE;
          end else begin
            fill_out_nxt = fill;
          end
        end
        default: begin
          status_nxt = ST_OK;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      out_valid_r <= 1'b0;
      blk_acc_r   <= 1'b0;
      alloc_cnt_r <= '0;
      meta_vld_r  <= '0;
    end else begin
      phase_r     <= phase_nxt;
      out_valid_r <= (phase_r == PH_EXEC);
      blk_acc_r   <= blk_acc_nxt;
      alloc_cnt_r <= alloc_cnt_nxt;
      if (meta_we) begin
        meta_vld_r[meta_waddr] <= 1'b1;
      end
    end
  end

  // Capture the command word and the result word
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r    <= in_kind;
      q_r       <= in_idx;
      oob_r     <= in_oob;
      vld_sel_r <= in_oob ? 1'b0 : meta_vld_r[in_idx];
      len_r     <= in_block_len;
      first_r   <= in_first;
      din_r     <= in_data_in;
    end
    if (phase_r == PH_EXEC) begin
      out_status_r <= status_nxt;
      out_handle_r <= handle_nxt;
      out_fill_r   <= fill_out_nxt;
      out_get_r    <= get_hit;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_handle     = out_handle_r;
  assign out_fill_count = FILLO_W'(out_fill_r);
  assign out_data_out   = out_get_r ? byte_rdata : '0;

  // A result strobe is preceded by an execute cycle
  a_out_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(phase_r) == PH_EXEC)
    else $error("result strobe without a preceding execute cycle");

  a_exec_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy ##1 out_valid)
    else $error("accepted word did not enter execute");

  a_alloc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    alloc_cnt_r <= AW'(QUEUE_COUNT))
    else $error("allocate count beyond queue count");

  a_data_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data_out != '0 |-> out_status == ST_OK)
    else $error("byte returned with a failing status");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_fill_r <= FW'(QUEUE_CAPACITY))
    else $error("reported fill exceeds capacity");

endmodule

`default_nettype wire
